// ----- rtl/core/tzfc_pkg.sv -----
// ----------------------------------------------------------------------------
// tzfc_pkg - shared types and constants for the fan controller core
// Frame and result payload types, configuration register codes and reset
// values, zone codes and the divide-by-100 reciprocal.
// ----------------------------------------------------------------------------
`default_nettype none

package tzfc_pkg;

    // Field widths
    localparam int unsigned TEMP_W    = 10;
    localparam int unsigned DUTY_W    = 7;
    localparam int unsigned TOP_W     = 16;
    localparam int unsigned CMP_W     = 17;
    localparam int unsigned ZONE_W    = 3;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 16;
    // (top + 1) * duty stays below 2^23
    localparam int unsigned PROD_W    = 23;
    // Reciprocal of 100, exact for any product below 2^23
    localparam int unsigned RECIP_W     = 24;
    localparam int unsigned RECIP_SHIFT = 30;
    localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;

    // Sensor reading limits and duty bounds
    localparam logic [TEMP_W-1:0] HELD_RESET  = 10'd250;
    localparam logic [11:0]       READING_MAX = 12'd800;
    localparam logic [BYTE_W-1:0] FRAC_MAX    = 8'd9;
    localparam logic [DUTY_W-1:0] FULL_DUTY   = 7'd100;
    localparam logic [DUTY_W-1:0] ZERO_DUTY   = 7'd0;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ZONE_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZONE_MID   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZONE_HIGH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_TWO   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_THREE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_TOP    = 3'd6;

    // Configuration reset values
    localparam logic [TEMP_W-1:0] RST_ZONE_LOW   = 10'd200;
    localparam logic [TEMP_W-1:0] RST_ZONE_MID   = 10'd260;
    localparam logic [TEMP_W-1:0] RST_ZONE_HIGH  = 10'd280;
    localparam logic [TEMP_W-1:0] RST_ALARM      = 10'd280;
    localparam logic [DUTY_W-1:0] RST_DUTY_TWO   = 7'd35;
    localparam logic [DUTY_W-1:0] RST_DUTY_THREE = 7'd70;
    localparam logic [TOP_W-1:0]  RST_PWM_TOP    = 16'd4199;

    // Zone codes
    localparam logic [ZONE_W-1:0] ZONE_1 = 3'd1;
    localparam logic [ZONE_W-1:0] ZONE_2 = 3'd2;
    localparam logic [ZONE_W-1:0] ZONE_3 = 3'd3;
    localparam logic [ZONE_W-1:0] ZONE_4 = 3'd4;

    typedef struct packed {
        logic [TEMP_W-1:0] zone_low;
        logic [TEMP_W-1:0] zone_mid;
        logic [TEMP_W-1:0] zone_high;
        logic [TEMP_W-1:0] alarm;
        logic [DUTY_W-1:0] duty_two;
        logic [DUTY_W-1:0] duty_three;
        logic [TOP_W-1:0]  pwm_top;
    } t_cfg;

    typedef struct packed {
        logic              frame_ok;
        logic [BYTE_W-1:0] humidity_whole;
        logic [BYTE_W-1:0] humidity_frac;
        logic [BYTE_W-1:0] temp_whole;
        logic [BYTE_W-1:0] temp_frac;
        logic [BYTE_W-1:0] frame_sum;
    } t_frame;

    // Everything but the final compare value, plus the raw product
    typedef struct packed {
        logic [TEMP_W-1:0] smoothed_temp;
        logic              sensor_ok;
        logic [ZONE_W-1:0] zone;
        logic [DUTY_W-1:0] fan_duty;
        logic [PROD_W-1:0] product;
        logic              led_red;
        logic              led_green;
        logic              led_blue;
        logic              alarm;
    } t_zone_res;

    typedef struct packed {
        logic [TEMP_W-1:0] smoothed_temp;
        logic              sensor_ok;
        logic [ZONE_W-1:0] zone;
        logic [DUTY_W-1:0] fan_duty;
        logic [CMP_W-1:0]  compare_value;
        logic              led_red;
        logic              led_green;
        logic              led_blue;
        logic              alarm;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/core/tzfc_frame_if.sv -----
// ----------------------------------------------------------------------------
// tzfc_frame_if - sensor frame channel
// Valid/ready channel carrying one decoded five-byte frame and its flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface tzfc_frame_if;
    logic       valid;
    logic       ready;
    logic       frame_ok;
    logic [7:0] humidity_whole;
    logic [7:0] humidity_frac;
    logic [7:0] temp_whole;
    logic [7:0] temp_frac;
    logic [7:0] frame_sum;

    modport source (
        output valid, frame_ok, humidity_whole, humidity_frac,
               temp_whole, temp_frac, frame_sum,
        input  ready
    );
    modport sink (
        input  valid, frame_ok, humidity_whole, humidity_frac,
               temp_whole, temp_frac, frame_sum,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/core/tzfc_result_if.sv -----
// ----------------------------------------------------------------------------
// tzfc_result_if - controller result channel
// Valid/ready channel carrying one fan control result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface tzfc_result_if;
    logic        valid;
    logic        ready;
    logic [9:0]  smoothed_temp;
    logic        sensor_ok;
    logic [2:0]  zone;
    logic [6:0]  fan_duty;
    logic [16:0] compare_value;
    logic        led_red;
    logic        led_green;
    logic        led_blue;
    logic        alarm;

    modport source (
        output valid, smoothed_temp, sensor_ok, zone, fan_duty,
               compare_value, led_red, led_green, led_blue, alarm,
        input  ready
    );
    modport sink (
        input  valid, smoothed_temp, sensor_ok, zone, fan_duty,
               compare_value, led_red, led_green, led_blue, alarm,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/core/tzfc_filter.sv -----
// ----------------------------------------------------------------------------
// tzfc_filter - frame check, smoothing and zone selection stage
// Validates the frame, updates the held reading and the smoothing state,
// picks the zone, duty and LEDs and forms (top + 1) * duty.
// ----------------------------------------------------------------------------
`default_nettype none

module tzfc_filter (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire tzfc_pkg::t_frame  i_frame,
    input  wire tzfc_pkg::t_cfg    i_cfg,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output tzfc_pkg::t_zone_res    o_res
);
    import tzfc_pkg::*;

    logic                r_valid;
    logic [TEMP_W-1:0]   r_held;
    logic [TEMP_W-1:0]   r_smooth;
    logic                r_first;
    t_zone_res           r_res;

    logic                take;
    logic [BYTE_W-1:0]   sum;
    logic [11:0]         reading;
    logic                frame_good;
    logic [TEMP_W-1:0]   n_held;
    logic [TEMP_W:0]     avg_sum;
    logic [TEMP_W-1:0]   n_smooth;
    logic [DUTY_W-1:0]   duty_two;
    logic [DUTY_W-1:0]   duty_three;
    logic [TOP_W:0]      period;
    logic [PROD_W-1:0]   product;
    t_zone_res           n_res;

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    // Check the frame and form the reading in tenths
    always_comb begin
        sum = i_frame.humidity_whole + i_frame.humidity_frac
            + i_frame.temp_whole + i_frame.temp_frac;
        reading = 12'(i_frame.temp_whole) * 12'd10;
        if (i_frame.temp_frac <= FRAC_MAX) begin
            reading = reading + 12'(i_frame.temp_frac);
        end
        frame_good = i_frame.frame_ok && (sum == i_frame.frame_sum)
                   && (reading <= READING_MAX);
        n_held = frame_good ? reading[TEMP_W-1:0] : r_held;
    end

    // Smooth: first sample as is, then average with the previous output
    always_comb begin
        avg_sum = {1'b0, r_smooth} + {1'b0, n_held};
        n_smooth = r_first ? n_held : avg_sum[TEMP_W:1];
    end

    // Pick zone, duty and LEDs; start the compare value product
    always_comb begin
        duty_two   = (i_cfg.duty_two > FULL_DUTY) ? FULL_DUTY : i_cfg.duty_two;
        duty_three = (i_cfg.duty_three > FULL_DUTY) ? FULL_DUTY : i_cfg.duty_three;
        n_res = '0;
        n_res.smoothed_temp = n_smooth;
        n_res.sensor_ok     = frame_good;
        n_res.alarm         = (n_smooth >= i_cfg.alarm);
        if (n_smooth < i_cfg.zone_low) begin
            n_res.zone      = ZONE_1;
            n_res.fan_duty  = ZERO_DUTY;
            n_res.led_blue  = 1'b1;
        end else if (n_smooth < i_cfg.zone_mid) begin
            n_res.zone      = ZONE_2;
            n_res.fan_duty  = duty_two;
            n_res.led_green = 1'b1;
        end else if (n_smooth < i_cfg.zone_high) begin
            n_res.zone      = ZONE_3;
            n_res.fan_duty  = duty_three;
            n_res.led_red   = 1'b1;
            n_res.led_green = 1'b1;
        end else begin
            n_res.zone      = ZONE_4;
            n_res.fan_duty  = FULL_DUTY;
            n_res.led_red   = 1'b1;
        end
        period        = {1'b0, i_cfg.pwm_top} + 17'd1;
        product       = PROD_W'(period) * PROD_W'(n_res.fan_duty);
        n_res.product = product;
    end

    // Advance the stage and the filter state on each taken item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_held   <= HELD_RESET;
            r_smooth <= '0;
            r_first  <= 1'b1;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (take) begin
                r_held   <= n_held;
                r_smooth <= n_smooth;
                r_first  <= 1'b0;
            end
        end
    end

    // Hold the payload until the next stage takes it
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res <= n_res;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/tzfc_pwm_div.sv -----
// ----------------------------------------------------------------------------
// tzfc_pwm_div - PWM compare value stage
// Divides (top + 1) * duty by 100 through a reciprocal multiply and
// registers the finished result item.
// ----------------------------------------------------------------------------
`default_nettype none

module tzfc_pwm_div (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire tzfc_pkg::t_zone_res  i_res,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output tzfc_pkg::t_result         o_result
);
    import tzfc_pkg::*;

    localparam int unsigned MUL_W = PROD_W + RECIP_W;

    logic               r_valid;
    t_result            r_result;
    logic [MUL_W-1:0]   scaled;
    t_result            n_result;
    logic               take;

    assign o_ready  = !r_valid || i_ready;
    assign take     = i_valid && o_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // Divide by 100: multiply by the scaled reciprocal and drop the fraction
    always_comb begin
        scaled = MUL_W'(i_res.product) * MUL_W'(RECIP_100);
        n_result.smoothed_temp = i_res.smoothed_temp;
        n_result.sensor_ok     = i_res.sensor_ok;
        n_result.zone          = i_res.zone;
        n_result.fan_duty      = i_res.fan_duty;
        n_result.compare_value = scaled[RECIP_SHIFT +: CMP_W];
        n_result.led_red       = i_res.led_red;
        n_result.led_green     = i_res.led_green;
        n_result.led_blue      = i_res.led_blue;
        n_result.alarm         = i_res.alarm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_result <= n_result;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/temperature_zone_fan_controller_core.sv -----
// ----------------------------------------------------------------------------
// temperature_zone_fan_controller_core - sensor frame to fan control core
// Pipeline: input register, filter/zone stage, divide stage, each registered.
// Throughput: one item per cycle while the result sink keeps ready high.
// Each stage holds its item under back-pressure and frees as it empties.
// Reset: synchronous active low; held reading 25.0, smoothing restarts,
// configuration registers return to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module temperature_zone_fan_controller_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    tzfc_frame_if.sink                               i_frame,
    tzfc_result_if.source                            o_result,
    input  wire logic                                i_cfg_we,
    input  wire logic [tzfc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [tzfc_pkg::CFG_DAT_W-1:0]      i_cfg_data
);
    import tzfc_pkg::*;

    t_cfg       r_cfg;
    logic       r_in_valid;
    t_frame     r_in_frame;
    t_frame     n_in_frame;

    logic       in_ready;
    logic       flt_ready;
    logic       flt_valid;
    t_zone_res  flt_res;
    logic       div_ready;
    logic       div_valid;
    t_result    div_result;

    // Configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zone_low   <= RST_ZONE_LOW;
            r_cfg.zone_mid   <= RST_ZONE_MID;
            r_cfg.zone_high  <= RST_ZONE_HIGH;
            r_cfg.alarm      <= RST_ALARM;
            r_cfg.duty_two   <= RST_DUTY_TWO;
            r_cfg.duty_three <= RST_DUTY_THREE;
            r_cfg.pwm_top    <= RST_PWM_TOP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ZONE_LOW:   r_cfg.zone_low   <= i_cfg_data[TEMP_W-1:0];
                CFG_ZONE_MID:   r_cfg.zone_mid   <= i_cfg_data[TEMP_W-1:0];
                CFG_ZONE_HIGH:  r_cfg.zone_high  <= i_cfg_data[TEMP_W-1:0];
                CFG_ALARM:      r_cfg.alarm      <= i_cfg_data[TEMP_W-1:0];
                CFG_DUTY_TWO:   r_cfg.duty_two   <= i_cfg_data[DUTY_W-1:0];
                CFG_DUTY_THREE: r_cfg.duty_three <= i_cfg_data[DUTY_W-1:0];
                CFG_PWM_TOP:    r_cfg.pwm_top    <= i_cfg_data[TOP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input register
    assign in_ready      = !r_in_valid || flt_ready;
    assign i_frame.ready = in_ready;

    always_comb begin
        n_in_frame.frame_ok       = i_frame.frame_ok;
        n_in_frame.humidity_whole = i_frame.humidity_whole;
        n_in_frame.humidity_frac  = i_frame.humidity_frac;
        n_in_frame.temp_whole     = i_frame.temp_whole;
        n_in_frame.temp_frac      = i_frame.temp_frac;
        n_in_frame.frame_sum      = i_frame.frame_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_frame.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_frame.valid) begin
            r_in_frame <= n_in_frame;
        end
    end

    tzfc_filter u_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .o_ready (flt_ready),
        .i_frame (r_in_frame),
        .i_cfg   (r_cfg),
        .o_valid (flt_valid),
        .i_ready (div_ready),
        .o_res   (flt_res)
    );

    tzfc_pwm_div u_pwm_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (flt_valid),
        .o_ready  (div_ready),
        .i_res    (flt_res),
        .o_valid  (div_valid),
        .i_ready  (o_result.ready),
        .o_result (div_result)
    );

    // Drive the result channel from the output register
    assign o_result.valid         = div_valid;
    assign o_result.smoothed_temp = div_result.smoothed_temp;
    assign o_result.sensor_ok     = div_result.sensor_ok;
    assign o_result.zone          = div_result.zone;
    assign o_result.fan_duty      = div_result.fan_duty;
    assign o_result.compare_value = div_result.compare_value;
    assign o_result.led_red       = div_result.led_red;
    assign o_result.led_green     = div_result.led_green;
    assign o_result.led_blue      = div_result.led_blue;
    assign o_result.alarm         = div_result.alarm;

endmodule

`default_nettype wire
